>>> rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Shared constants, codes and controller/datapath link types for the
// positional ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STEP_W   = $clog2(POS_W);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_REMOVE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_GET    = KIND_W'(2);

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);

  // read address select
  typedef enum logic [1:0] {
    RD_P    = 2'd0,  // target position
    RD_REM  = 2'd1,  // divider remainder
    RD_PREV = 2'd2,  // idx - 1
    RD_NEXT = 2'd3   // idx + 1
  } rd_sel_e;

  typedef struct packed {
    logic                load;
    logic                div_step;
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                wr_en;
    logic                wr_new;
    logic                idx_step;
    logic                cap_res;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                cnt_inc;
    logic                cnt_dec;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_empty;
    logic              is_full;
    logic              div_last;
    logic              at_end;
    logic              next_end;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/pol_dp.sv
// ----------------------------------------------------------------------------
// pol_dp
// Datapath: element memory, count, shift index, serial remainder unit and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pol_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [pol_pkg::POS_W-1:0]     position_i,
  input  wire logic [pol_pkg::DATA_W-1:0]    value_in_i,
  input  wire pol_pkg::cmd_t                 cmd_i,
  output pol_pkg::sts_t                      sts_o,
  output logic [pol_pkg::DATA_W-1:0]         res_o,
  output logic [pol_pkg::STATUS_W-1:0]       status_o,
  output logic [pol_pkg::CNT_W-1:0]          count_o
);
  import pol_pkg::*;

  logic [DATA_W-1:0]   mem [CAPACITY];
  logic [KIND_W-1:0]   kind_q;
  logic [ADDR_W-1:0]   p_q;
  logic [ADDR_W-1:0]   idx_q;
  logic [DATA_W-1:0]   val_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    rem_q;
  logic [POS_W-1:0]    dvd_q;
  logic [STEP_W-1:0]   step_q;
  logic [DATA_W-1:0]   rdata_q;
  logic [DATA_W-1:0]   res_q;
  logic [STATUS_W-1:0] status_q;

  logic [POS_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    ins_p;
  logic [CNT_W-1:0]    rm_p;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_sub;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                is_ins;

  assign is_ins  = (kind_q == KIND_INSERT);
  assign cnt_ext = POS_W'(cnt_q);

  // clamp: insert to count, remove to last element
  assign ins_p = (position_i > cnt_ext)  ? cnt_q : CNT_W'(position_i);
  assign rm_p  = (position_i >= cnt_ext) ? (cnt_q - CNT_W'(1)) : CNT_W'(position_i);

  // restoring remainder step, one quotient bit per cycle
  assign trial     = {rem_q, dvd_q[POS_W-1]};
  assign trial_sub = trial - {1'b0, cnt_q};

  always_comb begin
    case (cmd_i.rd_sel)
      RD_P:    rd_addr = p_q;
      RD_REM:  rd_addr = rem_q[ADDR_W-1:0];
      RD_PREV: rd_addr = idx_q - ADDR_W'(1);
      RD_NEXT: rd_addr = idx_q + ADDR_W'(1);
      default: rd_addr = p_q;
    endcase
  end

  assign wr_addr = cmd_i.wr_new ? p_q   : idx_q;
  assign wr_data = cmd_i.wr_new ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      kind_q   <= KIND_INSERT;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.load) begin
        kind_q   <= kind_i;
        status_q <= ST_OK;
      end else if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= value_in_i;
      p_q    <= (kind_i == KIND_REMOVE) ? ADDR_W'(rm_p) : ADDR_W'(ins_p);
      idx_q  <= (kind_i == KIND_INSERT) ? ADDR_W'(cnt_q) : ADDR_W'(rm_p);
      rem_q  <= '0;
      dvd_q  <= position_i;
      step_q <= '0;
      res_q  <= '0;
    end else begin
      if (cmd_i.div_step) begin
        rem_q  <= (trial >= {1'b0, cnt_q}) ? CNT_W'(trial_sub) : CNT_W'(trial);
        dvd_q  <= dvd_q << 1;
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.idx_step) begin
        idx_q <= is_ins ? (idx_q - ADDR_W'(1)) : (idx_q + ADDR_W'(1));
      end
      if (cmd_i.cap_res) begin
        res_q <= rdata_q;
      end
    end
  end

  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.is_empty = (cnt_q == '0);
    sts_o.is_full  = (cnt_q == CNT_W'(CAPACITY));
    sts_o.div_last = (step_q == STEP_W'(POS_W - 1));
    if (is_ins) begin
      sts_o.at_end   = (idx_q == p_q);
      sts_o.next_end = ((idx_q - ADDR_W'(1)) == p_q);
    end else begin
      sts_o.at_end   = ((CNT_W'(idx_q) + CNT_W'(1)) >= cnt_q);
      sts_o.next_end = ((CNT_W'(idx_q) + CNT_W'(2)) >= cnt_q);
    end
  end

  assign res_o    = res_q;
  assign status_o = status_q;
  assign count_o  = cnt_q;

endmodule

`default_nettype wire

>>> rtl/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl
// Sequencer: decodes the operation and steps the datapath through
// remainder, read, shift and write phases.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          out_free_i,
  input  wire pol_pkg::sts_t sts_i,
  output logic               in_ready_o,
  output logic               out_load_o,
  output pol_pkg::cmd_t      cmd_o
);
  import pol_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_RD_RES  = 9'b000001000,
    S_CAP_RES = 9'b000010000,
    S_SH_RD   = 9'b000100000,
    S_SH_WR   = 9'b001000000,
    S_WR_NEW  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.kind)
          KIND_INSERT: begin
            if (sts_i.is_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d          = S_DONE;
            end else if (sts_i.at_end) begin
              state_d = S_WR_NEW;
            end else begin
              state_d = S_SH_RD;
            end
          end
          KIND_REMOVE, KIND_GET: begin
            if (sts_i.is_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
              state_d          = S_DONE;
            end else if (sts_i.kind == KIND_GET) begin
              state_d = S_DIV;
            end else begin
              state_d = S_RD_RES;
            end
          end
          default: state_d = S_DONE;  // unused code: no-op
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RD_RES;
        end
      end
      S_RD_RES: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = (sts_i.kind == KIND_GET) ? RD_REM : RD_P;
        state_d      = S_CAP_RES;
      end
      S_CAP_RES: begin
        cmd_o.cap_res = 1'b1;
        if (sts_i.kind == KIND_REMOVE) begin
          if (sts_i.at_end) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_DONE;
          end else begin
            state_d = S_SH_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = (sts_i.kind == KIND_INSERT) ? RD_PREV : RD_NEXT;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.idx_step = 1'b1;
        if (!sts_i.next_end) begin
          state_d = S_SH_RD;
        end else if (sts_i.kind == KIND_INSERT) begin
          state_d = S_WR_NEW;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_WR_NEW: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/positional_ordered_list_top.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_top
// Ordered list of up to 64 data words with positional insert, remove and
// get, built as a sequencer driving a memory-based datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per operation:
//   kind_i (insert, remove, get), position_i and value_in_i. Output channel
//   (out_valid_o / out_ready_i) returns one word per operation: value_out_o,
//   status_o (ok, empty, full) and count_o after the operation.
//   One operation is in work at a time; a new one is taken once the previous
//   result has moved into the output register, even if that word is not yet
//   taken downstream.
//   Insert and remove move elements with one memory read and one write per
//   moved word; get first runs a serial remainder for position mod count;
//   errors and the unused code go straight to the result.
//   Reset clears the count and the sequencer; memory contents are not
//   cleared, only entries below the count are ever read.
//   If the receiver stalls, the result holds in the output register and the
//   next operation runs; the sequencer waits at its end until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pol_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [pol_pkg::POS_W-1:0]     position_i,
  input  wire logic [pol_pkg::DATA_W-1:0]    value_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pol_pkg::DATA_W-1:0]         value_out_o,
  output logic [pol_pkg::STATUS_W-1:0]       status_o,
  output logic [pol_pkg::CNT_W-1:0]          count_o
);
  import pol_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic                out_free;
  logic                out_load;
  logic [DATA_W-1:0]   dp_res;
  logic [STATUS_W-1:0] dp_status;
  logic [CNT_W-1:0]    dp_count;

  // output word register
  logic                out_valid_q;
  logic [DATA_W-1:0]   value_out_q;
  logic [STATUS_W-1:0] status_q;
  logic [CNT_W-1:0]    count_q;

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  pol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  pol_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_in_i (value_in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (dp_res),
    .status_o   (dp_status),
    .count_o    (dp_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_out_q <= dp_res;
      status_q    <= dp_status;
      count_q     <= dp_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

`ifndef SYNTHESIS
  // count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(CAPACITY)))
    else $error("count above capacity");

  // full is only reported with a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (count_o == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  // empty is only reported with an empty list and a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> ((count_o == '0) && (value_out_o == '0)))
    else $error("empty status inconsistent");

  // after accepting a word the block is busy and does not accept another back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted two words back to back");
`endif

endmodule

`default_nettype wire
